// ===== src/segint_pkg.sv =====
// ============================================================================
// Segment intersection package
// Shared constants, field positions and result types for the segment
// intersection test block.
// ============================================================================
package segint_pkg;

   // Default coordinate width of every endpoint field.
   localparam int COORD_BITS_DEFAULT = 16;

   // Number of coordinate fields in one request beat.
   localparam int NUM_FIELDS = 8;

   // Field positions inside the request payload, lowest field first.
   localparam int FLD_A_START_X = 0;
   localparam int FLD_A_START_Y = 1;
   localparam int FLD_A_END_X   = 2;
   localparam int FLD_A_END_Y   = 3;
   localparam int FLD_B_START_X = 4;
   localparam int FLD_B_START_Y = 5;
   localparam int FLD_B_END_X   = 6;
   localparam int FLD_B_END_Y   = 7;

   // Response payload: crosses, outcome, then zero fill to one byte.
   localparam int OUTCOME_BITS = 3;
   localparam int RSP_BITS     = 8;
   localparam int RSP_PAD_BITS = RSP_BITS - OUTCOME_BITS - 1;

   typedef enum logic [OUTCOME_BITS-1:0] {
      OUTCOME_PROPER   = 3'd0,
      OUTCOME_PARALLEL = 3'd1,
      OUTCOME_SHARED   = 3'd2,
      OUTCOME_TOUCHING = 3'd3,
      OUTCOME_DISJOINT = 3'd4
   } outcome_type;

   // Turning sense of three points, or collinear.
   typedef enum logic [1:0] {
      ORIENT_COLLINEAR = 2'd0,
      ORIENT_POS       = 2'd1,
      ORIENT_NEG       = 2'd2
   } orient_type;

   typedef struct packed {
      logic        crosses;
      outcome_type outcome;
   } result_type;

endpackage

// ===== src/segment_intersection_test.sv =====
// ============================================================================
// Segment intersection test
// Decides whether two integer line segments cross and classifies the pair.
// ============================================================================
// Stages: two register stages, the input register then the response register;
//   a response beat is valid once its request has passed through both.
// Throughput: one pair per cycle unless rsp_tready stalls; the five cross-product
//   units between the input and response registers set the clock period.
// Reset: synchronous, active high; clears both valid flags, payload is not reset.
// ----------------------------------------------------------------------------
//
// Structure: the request beat is captured in an input register. The classifier
// works on that register combinationally, and its result is captured in the
// response register. Each register advances whenever the stage behind it is
// empty or is being drained, so the block can still take a request beat into an
// empty input register while a finished response waits for rsp_tready.
//
// Classification order, first match wins: parallel (zero direction cross
// product, which also covers a segment of zero length), shared endpoint,
// touching (an endpoint lies on the other segment), proper crossing, disjoint.
// All cross products are kept at full width, so nothing is truncated.
module segment_intersection_test #(
   parameter int COORD_BITS = segint_pkg::COORD_BITS_DEFAULT,
   // Request port width: the eight coordinates rounded up to whole bytes.
   localparam int REQ_BITS  = ((segint_pkg::NUM_FIELDS * COORD_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,

   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
   // b_start_x, b_start_y, b_end_x, b_end_y (COORD_BITS each), zero fill.
   input  logic [REQ_BITS-1:0] req_tdata,

   // Response channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // Fields from bit 0 up: crosses (1), outcome (3), zero fill to 8 bits.
   output logic [segint_pkg::RSP_BITS-1:0] rsp_tdata
);

   // Payload bits of one request.
   localparam int PAIR_BITS = segint_pkg::NUM_FIELDS * COORD_BITS;

   // Input register.
   logic                   in_valid_ff, in_valid_in;
   logic [PAIR_BITS-1:0]   in_pair_ff;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   segint_pkg::result_type rsp_result_ff;

   segint_pkg::result_type result;
   logic                   req_take;
   logic                   rsp_load;

   // The response register can take new data when it is empty or is being
   // read out this cycle; the input register frees up whenever it moves on.
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || rsp_load;
   assign req_take   = req_tvalid && req_tready;

   segint_classify #(.COORD_BITS(COORD_BITS)) u_classify (
      .pair   (in_pair_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on their stage's advance and need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pair_ff <= req_tdata[PAIR_BITS-1:0];
      end
      if (rsp_load && in_valid_ff) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{segint_pkg::RSP_PAD_BITS{1'b0}},
                        rsp_result_ff.outcome, rsp_result_ff.crosses};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // Both valid flags are clear in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_valid_ff))
      else $error("valid flag set after reset");

   // A taken request beat always occupies the input register next cycle.
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("request beat lost");

   // A stalled input register keeps its pair.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_load) |=> (in_valid_ff && $stable(in_pair_ff)))
      else $error("stalled pair changed");

   // The crossing flag agrees with the outcome class.
   a_crosses_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_result_ff.crosses ==
         ((rsp_result_ff.outcome == segint_pkg::OUTCOME_PROPER) ||
          (rsp_result_ff.outcome == segint_pkg::OUTCOME_TOUCHING))))
      else $error("crosses disagrees with outcome");

   // A pair moved into the response register is never dropped while stalled.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_result_ff)))
      else $error("stalled response changed");

endmodule

// ===== src/segint_orient.sv =====
// ============================================================================
// Segment intersection orientation unit
// Computes m0*m1 - n0*n1 at full width on coordinate differences and
// reports its sign as an orientation code.
// ============================================================================
module segint_orient #(
   parameter int COORD_BITS = segint_pkg::COORD_BITS_DEFAULT
) (
   input  logic signed [COORD_BITS:0] m0,
   input  logic signed [COORD_BITS:0] m1,
   input  logic signed [COORD_BITS:0] n0,
   input  logic signed [COORD_BITS:0] n1,
   output segint_pkg::orient_type     orient
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;

   logic signed [PROD_BITS-1:0] prod_m;
   logic signed [PROD_BITS-1:0] prod_n;
   logic signed [PROD_BITS:0]   value;

   assign prod_m = m0 * m1;
   assign prod_n = n0 * n1;
   assign value  = {prod_m[PROD_BITS-1], prod_m} - {prod_n[PROD_BITS-1], prod_n};

   always_comb begin
      if (value == '0) begin
         orient = segint_pkg::ORIENT_COLLINEAR;
      end else if (value[PROD_BITS]) begin
         orient = segint_pkg::ORIENT_NEG;
      end else begin
         orient = segint_pkg::ORIENT_POS;
      end
   end

endmodule

// ===== src/segint_classify.sv =====
// ============================================================================
// Segment intersection classifier
// Single-pass combinational classification of one registered segment pair
// into parallel, shared endpoint, touching, proper crossing or disjoint.
// ============================================================================
module segint_classify #(
   parameter int COORD_BITS = segint_pkg::COORD_BITS_DEFAULT
) (
   input  logic [segint_pkg::NUM_FIELDS*COORD_BITS-1:0] pair,
   output segint_pkg::result_type                       result
);

   localparam int DIFF_BITS = COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
   segint_pkg::orient_type       dir_o, o1, o2, o3, o4;
   logic                         shared, touching, proper;

   assign a0x = pair[segint_pkg::FLD_A_START_X*COORD_BITS +: COORD_BITS];
   assign a0y = pair[segint_pkg::FLD_A_START_Y*COORD_BITS +: COORD_BITS];
   assign a1x = pair[segint_pkg::FLD_A_END_X*COORD_BITS   +: COORD_BITS];
   assign a1y = pair[segint_pkg::FLD_A_END_Y*COORD_BITS   +: COORD_BITS];
   assign b0x = pair[segint_pkg::FLD_B_START_X*COORD_BITS +: COORD_BITS];
   assign b0y = pair[segint_pkg::FLD_B_START_Y*COORD_BITS +: COORD_BITS];
   assign b1x = pair[segint_pkg::FLD_B_END_X*COORD_BITS   +: COORD_BITS];
   assign b1y = pair[segint_pkg::FLD_B_END_Y*COORD_BITS   +: COORD_BITS];

   // Exact difference of two coordinates, one bit wider than the inputs.
   function automatic logic signed [DIFF_BITS-1:0] diff(
      input logic signed [COORD_BITS-1:0] lhs,
      input logic signed [COORD_BITS-1:0] rhs
   );
      logic signed [DIFF_BITS-1:0] res;
      res = {lhs[COORD_BITS-1], lhs} - {rhs[COORD_BITS-1], rhs};
      return res;
   endfunction

   // q inside the bounding box spanned by p and r.
   function automatic logic in_box(
      input logic signed [COORD_BITS-1:0] px, py, qx, qy, rx, ry
   );
      logic signed [COORD_BITS-1:0] lox, hix, loy, hiy;
      lox = (px < rx) ? px : rx;
      hix = (px < rx) ? rx : px;
      loy = (py < ry) ? py : ry;
      hiy = (py < ry) ? ry : py;
      return (qx >= lox) && (qx <= hix) && (qy >= loy) && (qy <= hiy);
   endfunction

   // Direction cross product; zero means parallel, collinear or degenerate.
   segint_orient #(.COORD_BITS(COORD_BITS)) u_dir (
      .m0(diff(a1x, a0x)), .m1(diff(b1y, b0y)),
      .n0(diff(a1y, a0y)), .n1(diff(b1x, b0x)),
      .orient(dir_o)
   );

   // orient(p, q, r) = (q.y - p.y)(r.x - q.x) - (q.x - p.x)(r.y - q.y)
   segint_orient #(.COORD_BITS(COORD_BITS)) u_o1 (
      .m0(diff(a1y, a0y)), .m1(diff(b0x, a1x)),
      .n0(diff(a1x, a0x)), .n1(diff(b0y, a1y)),
      .orient(o1)
   );

   segint_orient #(.COORD_BITS(COORD_BITS)) u_o2 (
      .m0(diff(a1y, a0y)), .m1(diff(b1x, a1x)),
      .n0(diff(a1x, a0x)), .n1(diff(b1y, a1y)),
      .orient(o2)
   );

   segint_orient #(.COORD_BITS(COORD_BITS)) u_o3 (
      .m0(diff(b1y, b0y)), .m1(diff(a0x, b1x)),
      .n0(diff(b1x, b0x)), .n1(diff(a0y, b1y)),
      .orient(o3)
   );

   segint_orient #(.COORD_BITS(COORD_BITS)) u_o4 (
      .m0(diff(b1y, b0y)), .m1(diff(a1x, b1x)),
      .n0(diff(b1x, b0x)), .n1(diff(a1y, b1y)),
      .orient(o4)
   );

   assign shared = ((a0x == b0x) && (a0y == b0y)) || ((a0x == b1x) && (a0y == b1y)) ||
                   ((a1x == b0x) && (a1y == b0y)) || ((a1x == b1x) && (a1y == b1y));

   assign touching =
      ((o1 == segint_pkg::ORIENT_COLLINEAR) && in_box(a0x, a0y, b0x, b0y, a1x, a1y)) ||
      ((o2 == segint_pkg::ORIENT_COLLINEAR) && in_box(a0x, a0y, b1x, b1y, a1x, a1y)) ||
      ((o3 == segint_pkg::ORIENT_COLLINEAR) && in_box(b0x, b0y, a0x, a0y, b1x, b1y)) ||
      ((o4 == segint_pkg::ORIENT_COLLINEAR) && in_box(b0x, b0y, a1x, a1y, b1x, b1y));

   assign proper = (o1 != o2) && (o3 != o4);

   always_comb begin
      if (dir_o == segint_pkg::ORIENT_COLLINEAR) begin
         result.outcome = segint_pkg::OUTCOME_PARALLEL;
      end else if (shared) begin
         result.outcome = segint_pkg::OUTCOME_SHARED;
      end else if (touching) begin
         result.outcome = segint_pkg::OUTCOME_TOUCHING;
      end else if (proper) begin
         result.outcome = segint_pkg::OUTCOME_PROPER;
      end else begin
         result.outcome = segint_pkg::OUTCOME_DISJOINT;
      end
      result.crosses = (result.outcome == segint_pkg::OUTCOME_PROPER) ||
                       (result.outcome == segint_pkg::OUTCOME_TOUCHING);
   end

endmodule
